/* design/mtsg_pkg.sv */
// ----------------------------------------------------------------------------
// mtsg_pkg: shared types, codes and table builders
// Mode and register codes, unit handshake structs, saturation and the
// elaboration-time builders for the sine and lag tables.
// ----------------------------------------------------------------------------
package mtsg_pkg;

    localparam int FRAC_BITS = 16;

    typedef enum logic [2:0] {
        MODE_SINE    = 3'd0,
        MODE_RAMP    = 3'd1,
        MODE_COUNTER = 3'd2,
        MODE_TOGGLE  = 3'd3,
        MODE_FOLLOW  = 3'd4
    } mode_t;

    localparam logic [2:0] CFG_MODE   = 3'd0;
    localparam logic [2:0] CFG_MIN    = 3'd1;
    localparam logic [2:0] CFG_MAX    = 3'd2;
    localparam logic [2:0] CFG_STEP   = 3'd3;
    localparam logic [2:0] CFG_RATED  = 3'd4;
    localparam logic [2:0] CFG_PERIOD = 3'd5;
    localparam logic [2:0] CFG_TAU    = 3'd6;

    localparam logic [63:0] PI_Q30  = 64'd3373259426;
    localparam logic [63:0] ONE_Q30 = 64'd1 << 30;

    // divider request: dividend is left aligned, nbits quotient bits are made
    typedef struct packed {
        logic        start;
        logic [63:0] dividend;
        logic [31:0] divisor;
        logic [6:0]  nbits;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] quot;
        logic [31:0] rem;
    } div_stat_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647)
            r = 32'sh7FFFFFFF;
        else if (v < -64'sd2147483648)
            r = 32'sh80000000;
        else
            r = 32'(v);
        return r;
    endfunction

    // shift-subtract quotient for the table builders; elaboration only
    function automatic logic [63:0] div64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [64:0] r;
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--)
        begin
            r = {r[63:0], num[b]};
            if (r >= {1'b0, den})
            begin
                r    = r - {1'b0, den};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // sin over the first quadrant, Q16, capped at 65535
    function automatic logic [15:0] sine_entry(input int unsigned i, input int unsigned bits);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] pos;
        logic [63:0] neg;
        logic [63:0] s;
        logic [63:0] r;
        logic [63:0] den;
        x = (PI_Q30 * 64'(i)) >> (bits + 1);
        x2 = (x * x) >> 30;
        term = x;
        pos = x;
        neg = 64'd0;
        for (int k = 1; k <= 9; k++) begin
            den = 64'((2 * k) * (2 * k + 1));
            term = div64((term * x2) >> 30, den);
            if ((k % 2) == 1)
                neg = neg + term;
            else
                pos = pos + term;
        end
        s = (pos >= neg) ? pos - neg : 64'd0;
        r = (s + 64'd8192) >> 14;
        return (r > 64'd65535) ? 16'hFFFF : r[15:0];
    endfunction

    // 1 - exp(-8y), Q16
    function automatic logic [15:0] lag_entry(input int unsigned i, input int unsigned bits);
        logic [63:0] y;
        logic [63:0] term;
        logic [63:0] pos;
        logic [63:0] neg;
        logic [63:0] e;
        logic [63:0] r;
        y = 64'(i) << (30 - bits);
        term = ONE_Q30;
        pos = ONE_Q30;
        neg = 64'd0;
        for (int k = 1; k <= 13; k++) begin
            term = div64((term * y) >> 30, 64'(k));
            if ((k % 2) == 1)
                neg = neg + term;
            else
                pos = pos + term;
        end
        e = (pos >= neg) ? pos - neg : 64'd0;
        for (int k = 0; k < 3; k++)
            e = (e * e) >> 30;
        if (e > ONE_Q30)
            e = ONE_Q30;
        r = ((ONE_Q30 - e) + 64'd8192) >> 14;
        return (r > 64'd65535) ? 16'hFFFF : r[15:0];
    endfunction

endpackage

/* design/mtsg_div.sv */
// ----------------------------------------------------------------------------
// mtsg_div: shared restoring divider
// One quotient bit per cycle over a left-aligned dividend, 32-bit divisor.
// ----------------------------------------------------------------------------
module mtsg_div
    import mtsg_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  div_req_t  req,
    output div_stat_t stat
);

    logic [63:0] dq_reg;
    logic [31:0] rem_reg;
    logic [31:0] dvs_reg;
    logic [6:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;

    logic [32:0] trial;
    logic [32:0] diff;
    logic        ge;

    assign trial = {rem_reg, dq_reg[63]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign ge    = trial >= {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= req.nbits;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            dq_reg  <= req.dividend;
            rem_reg <= '0;
            dvs_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            dq_reg  <= {dq_reg[62:0], ge};
            rem_reg <= ge ? diff[31:0] : trial[31:0];
        end
    end

    assign stat.done = done_reg;
    assign stat.quot = dq_reg;
    assign stat.rem  = rem_reg;

endmodule

/* design/mtsg_mul.sv */
// ----------------------------------------------------------------------------
// mtsg_mul: shared signed multiplier
// 34 x 34 signed product, registered.
// ----------------------------------------------------------------------------
module mtsg_mul
(
    input  logic               clk,
    input  logic               en,
    input  logic signed [33:0] a,
    input  logic signed [33:0] b,
    output logic signed [67:0] p
);

    logic signed [67:0] p_reg;

    always_ff @(posedge clk)
    begin
        if (en)
            p_reg <= a * b;
    end

    assign p = p_reg;

endmodule

/* design/mtsg_tables.sv */
// ----------------------------------------------------------------------------
// mtsg_tables: sine quarter-wave and lag ROMs
// Constant contents built at elaboration, one registered read port each.
// ----------------------------------------------------------------------------
module mtsg_tables
    import mtsg_pkg::*;
#(
    parameter int SINE_BITS = 10,
    parameter int LAG_BITS  = 10
)
(
    input  logic                 clk,
    input  logic                 sine_en,
    input  logic [SINE_BITS-1:0] sine_addr,
    output logic [15:0]          sine_data,
    input  logic                 lag_en,
    input  logic [LAG_BITS:0]    lag_addr,
    output logic [15:0]          lag_data
);

    localparam int SINE_N = 1 << SINE_BITS;
    localparam int LAG_N  = 1 << LAG_BITS;

    typedef logic [15:0] sine_rom_t [SINE_N];
    typedef logic [15:0] lag_rom_t [LAG_N + 1];

    function automatic sine_rom_t build_sine();
        sine_rom_t t;
        for (int i = 0; i < SINE_N; i++)
            t[i] = sine_entry(i, SINE_BITS);
        return t;
    endfunction

    function automatic lag_rom_t build_lag();
        lag_rom_t t;
        for (int i = 0; i <= LAG_N; i++)
            t[i] = lag_entry(i, LAG_BITS);
        return t;
    endfunction

    localparam sine_rom_t SINE_ROM = build_sine();
    localparam lag_rom_t  LAG_ROM  = build_lag();

    logic [15:0] sine_data_reg;
    logic [15:0] lag_data_reg;

    always_ff @(posedge clk)
    begin
        if (sine_en)
            sine_data_reg <= SINE_ROM[sine_addr];
        if (lag_en)
            lag_data_reg <= LAG_ROM[lag_addr];
    end

    assign sine_data = sine_data_reg;
    assign lag_data  = lag_data_reg;

endmodule

/* design/multimode_test_signal_generator.sv */
// ----------------------------------------------------------------------------
// multimode_test_signal_generator: sine / ramp / counter / toggle / follow
// Sequencer around one shared divider, one shared multiplier and two ROMs.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): one word per time tick, dt_us and
//   command. Output channel (out_valid / out_stall): one Q16.16 level word
//   per tick. Config port: cfg_we / cfg_addr / cfg_wdata, written while idle;
//   writes to addresses 0-6 reload elapsed time, current level and toggle state.
// Work per word, accept to next accept, is set by the bit-serial divider
// (one quotient bit a cycle):
//   counter, unused modes: no division
//   toggle: no division, or a modulo division when the period wraps
//   sine:   modulo, phase division, table read, multiply
//   ramp:   modulo, multiply, 64-bit quotient
//   follow: ratio division, table reads, interpolation, multiply;
//           settles on the target when the ratio is past the table end
// One word is in flight at a time; in_stall is high until the level is
// loaded into the output register.
// Reset: registers go to their documented defaults, counter mode, state
//   reloaded; ROMs are constant and need no fill.
// A stalled receiver holds the finished level in the output register; the
//   sequencer waits in its last state until the register is free.
// ----------------------------------------------------------------------------
module multimode_test_signal_generator
    import mtsg_pkg::*;
#(
    parameter int SINE_TABLE_BITS = 10,
    parameter int LAG_TABLE_BITS  = 10
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [23:0]        dt_us,
    input  logic               command,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] level,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_addr,
    input  logic [31:0]        cfg_wdata
);

    localparam int SB = SINE_TABLE_BITS;
    localparam int LB = LAG_TABLE_BITS;
    localparam logic [6:0] MOD_BITS = 7'd33;
    localparam logic [6:0] PH_BITS  = 7'(32 + SB + 2);
    localparam logic [6:0] RMP_BITS = 7'd64;
    localparam logic [6:0] FOL_BITS = 7'(24 + LB + 13);
    localparam logic signed [31:0] TOG_ONE = 32'sd1 <<< FRAC_BITS;

    typedef enum logic [13:0] {
        S_IDLE  = 14'b00000000000001,
        S_MOD   = 14'b00000000000010,
        S_PHASE = 14'b00000000000100,
        S_SREAD = 14'b00000000001000,
        S_SMUL  = 14'b00000000010000,
        S_RMUL  = 14'b00000000100000,
        S_RDIV  = 14'b00000001000000,
        S_FDIV  = 14'b00000010000000,
        S_FR0   = 14'b00000100000000,
        S_FR1   = 14'b00001000000000,
        S_FINT  = 14'b00010000000000,
        S_FM    = 14'b00100000000000,
        S_FCALC = 14'b01000000000000,
        S_DONE  = 14'b10000000000000
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [2:0]         mode_reg, mode_next;
    logic signed [31:0] min_reg, min_next;
    logic signed [31:0] max_reg, max_next;
    logic [30:0]        step_reg, step_next;
    logic signed [31:0] rated_reg, rated_next;
    logic [31:0]        period_reg, period_next;
    logic [31:0]        tau_reg, tau_next;

    // generator state
    logic [31:0]        elapsed_reg, elapsed_next;
    logic signed [31:0] cur_reg, cur_next;
    logic               tog_reg, tog_next;

    // per-word scratch
    logic               cmd_reg, cmd_next;
    logic [1:0]         quad_reg, quad_next;
    logic               izero_reg, izero_next;
    logic [LB-1:0]      j_reg, j_next;
    logic [15:0]        frac_reg, frac_next;
    logic [15:0]        lj_reg, lj_next;
    logic [15:0]        f_reg, f_next;
    logic signed [31:0] res_reg, res_next;
    logic               out_valid_reg, out_valid_next;
    logic signed [31:0] level_reg, level_next;

    // shared units
    div_req_t           div_req;
    div_stat_t          div_stat;
    logic               mul_en;
    logic signed [33:0] mul_a;
    logic signed [33:0] mul_b;
    logic signed [67:0] mul_p;
    logic               sine_en;
    logic [SB-1:0]      sine_addr;
    logic [15:0]        sine_data;
    logic               lag_en;
    logic [LB:0]        lag_addr;
    logic [15:0]        lag_data;

    // helpers
    logic               accept;
    logic [31:0]        per_eff;
    logic [31:0]        tau_eff;
    logic signed [32:0] span;
    logic [32:0]        mag;
    logic [32:0]        tsum;
    logic signed [32:0] cnt_sum;
    logic signed [31:0] target;
    logic signed [32:0] fdiff;
    logic [SB+1:0]      phase;
    logic [SB-1:0]      pidx;
    logic signed [17:0] sval;
    logic signed [63:0] wide;
    logic               out_free;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign out_free = !out_valid_reg || !out_stall;
    assign per_eff  = (period_reg == 32'd0) ? 32'd1 : period_reg;
    assign tau_eff  = (tau_reg == 32'd0) ? 32'd1 : tau_reg;
    assign span     = 33'(max_reg) - 33'(min_reg);
    assign mag      = span[32] ? 33'(-span) : 33'(span);
    assign tsum     = {1'b0, elapsed_reg} + {9'd0, dt_us};
    assign cnt_sum  = 33'(cur_reg) + $signed({2'b00, step_reg});
    assign target   = cmd_reg ? rated_reg : 32'sd0;
    assign fdiff    = 33'(target) - 33'(cur_reg);
    assign phase    = div_stat.quot[SB+1:0];
    assign pidx     = phase[SB-1:0];

    mtsg_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .stat  (div_stat)
    );

    mtsg_mul u_mul
    (
        .clk (clk),
        .en  (mul_en),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    mtsg_tables #(
        .SINE_BITS (SB),
        .LAG_BITS  (LB)
    ) u_tables
    (
        .clk       (clk),
        .sine_en   (sine_en),
        .sine_addr (sine_addr),
        .sine_data (sine_data),
        .lag_en    (lag_en),
        .lag_addr  (lag_addr),
        .lag_data  (lag_data)
    );

    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        min_next       = min_reg;
        max_next       = max_reg;
        step_next      = step_reg;
        rated_next     = rated_reg;
        period_next    = period_reg;
        tau_next       = tau_reg;
        elapsed_next   = elapsed_reg;
        cur_next       = cur_reg;
        tog_next       = tog_reg;
        cmd_next       = cmd_reg;
        quad_next      = quad_reg;
        izero_next     = izero_reg;
        j_next         = j_reg;
        frac_next      = frac_reg;
        lj_next        = lj_reg;
        f_next         = f_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        level_next     = level_reg;
        div_req        = '0;
        mul_en         = 1'b0;
        mul_a          = '0;
        mul_b          = '0;
        sine_en        = 1'b0;
        sine_addr      = '0;
        lag_en         = 1'b0;
        lag_addr       = '0;
        sval           = '0;
        wide           = '0;

        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next = command;
                    unique case (mode_reg)
                        MODE_SINE, MODE_RAMP:
                        begin
                            div_req.start    = 1'b1;
                            div_req.dividend = {tsum, 31'd0};
                            div_req.divisor  = per_eff;
                            div_req.nbits    = MOD_BITS;
                            state_next       = S_MOD;
                        end
                        MODE_COUNTER:
                        begin
                            if (cnt_sum > 33'(max_reg))
                                cur_next = min_reg;
                            else
                                cur_next = cnt_sum[31:0];
                            res_next   = cur_next;
                            state_next = S_DONE;
                        end
                        MODE_TOGGLE:
                        begin
                            if (tsum >= {1'b0, per_eff})
                            begin
                                div_req.start    = 1'b1;
                                div_req.dividend = {tsum, 31'd0};
                                div_req.divisor  = per_eff;
                                div_req.nbits    = MOD_BITS;
                                state_next       = S_MOD;
                            end
                            else
                            begin
                                elapsed_next = tsum[31:0];
                                res_next     = tog_reg ? TOG_ONE : 32'sd0;
                                state_next   = S_DONE;
                            end
                        end
                        MODE_FOLLOW:
                        begin
                            div_req.start    = 1'b1;
                            div_req.dividend = {dt_us, 40'd0};
                            div_req.divisor  = tau_eff;
                            div_req.nbits    = FOL_BITS;
                            state_next       = S_FDIV;
                        end
                        default:
                        begin
                            res_next   = 32'sd0;
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            S_MOD:
            begin
                if (div_stat.done)
                begin
                    elapsed_next = div_stat.rem;
                    if (mode_reg == MODE_TOGGLE)
                    begin
                        tog_next   = !tog_reg;
                        res_next   = tog_reg ? 32'sd0 : TOG_ONE;
                        state_next = S_DONE;
                    end
                    else if (mode_reg == MODE_SINE)
                    begin
                        div_req.start    = 1'b1;
                        div_req.dividend = {div_stat.rem, 32'd0};
                        div_req.divisor  = per_eff;
                        div_req.nbits    = PH_BITS;
                        state_next       = S_PHASE;
                    end
                    else
                    begin
                        mul_en     = 1'b1;
                        mul_a      = $signed({2'b00, mag[31:0]});
                        mul_b      = $signed({2'b00, div_stat.rem});
                        state_next = S_RMUL;
                    end
                end
            end

            S_PHASE:
            begin
                if (div_stat.done)
                begin
                    quad_next  = phase[SB+1:SB];
                    izero_next = (pidx == '0);
                    sine_en    = 1'b1;
                    sine_addr  = phase[SB] ? SB'(~pidx + 1'b1) : pidx;
                    state_next = S_SREAD;
                end
            end

            S_SREAD:
            begin
                // odd quadrant with index zero is the peak, one past the table
                if (quad_reg[0] && izero_reg)
                    sval = 18'sd65536;
                else
                    sval = $signed({2'b00, sine_data});
                if (quad_reg[1])
                    sval = -sval;
                mul_en     = 1'b1;
                mul_a      = 34'(span);
                mul_b      = 34'(sval);
                state_next = S_SMUL;
            end

            S_SMUL:
            begin
                wide       = (64'(33'(min_reg) + 33'(max_reg)) <<< 16) + 64'(mul_p);
                res_next   = sat32(wide >>> 17);
                state_next = S_DONE;
            end

            S_RMUL:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = mul_p[63:0];
                div_req.divisor  = per_eff;
                div_req.nbits    = RMP_BITS;
                state_next       = S_RDIV;
            end

            S_RDIV:
            begin
                if (div_stat.done)
                begin
                    if (span[32])
                        wide = 64'(min_reg) - $signed({32'd0, div_stat.quot[31:0]});
                    else
                        wide = 64'(min_reg) + $signed({32'd0, div_stat.quot[31:0]});
                    res_next   = sat32(wide);
                    state_next = S_DONE;
                end
            end

            S_FDIV:
            begin
                if (div_stat.done)
                begin
                    if (div_stat.quot[63:16+LB] != '0)
                    begin
                        // ratio of eight or more time constants: settled
                        cur_next   = target;
                        res_next   = target;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        j_next     = div_stat.quot[16+LB-1:16];
                        frac_next  = div_stat.quot[15:0];
                        lag_en     = 1'b1;
                        lag_addr   = {1'b0, div_stat.quot[16+LB-1:16]};
                        state_next = S_FR0;
                    end
                end
            end

            S_FR0:
            begin
                lj_next    = lag_data;
                lag_en     = 1'b1;
                lag_addr   = {1'b0, j_reg} + 1'b1;
                state_next = S_FR1;
            end

            S_FR1:
            begin
                if (lag_data >= lj_reg)
                begin
                    mul_en     = 1'b1;
                    mul_a      = $signed({18'd0, 16'(lag_data - lj_reg)});
                    mul_b      = $signed({18'd0, frac_reg});
                    state_next = S_FINT;
                end
                else
                begin
                    f_next     = lj_reg;
                    state_next = S_FM;
                end
            end

            S_FINT:
            begin
                f_next     = lj_reg + mul_p[31:16];
                state_next = S_FM;
            end

            S_FM:
            begin
                mul_en     = 1'b1;
                mul_a      = 34'(fdiff);
                mul_b      = $signed({18'd0, f_reg});
                state_next = S_FCALC;
            end

            S_FCALC:
            begin
                wide       = 64'(cur_reg) + 64'(mul_p >>> 16);
                cur_next   = sat32(wide);
                res_next   = cur_next;
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    level_next     = res_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // register writes must arrive only while idle (the block does not enforce it); writes to 0-6 reload the state
        if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_MODE:   mode_next   = cfg_wdata[2:0];
                CFG_MIN:    min_next    = cfg_wdata;
                CFG_MAX:    max_next    = cfg_wdata;
                CFG_STEP:   step_next   = cfg_wdata[30:0];
                CFG_RATED:  rated_next  = cfg_wdata;
                CFG_PERIOD: period_next = cfg_wdata;
                CFG_TAU:    tau_next    = cfg_wdata;
                default:    ;
            endcase
            if (cfg_addr <= CFG_TAU)
            begin
                elapsed_next = 32'd0;
                cur_next     = (mode_next == MODE_COUNTER) ? min_next : 32'sd0;
                tog_next     = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mode_reg      <= MODE_COUNTER;
            min_reg       <= 32'sd0;
            max_reg       <= 32'sd6553600;
            step_reg      <= 31'd65536;
            rated_reg     <= 32'sd95027200;
            period_reg    <= 32'd30000000;
            tau_reg       <= 32'd3000000;
            elapsed_reg   <= 32'd0;
            cur_reg       <= 32'sd0;
            tog_reg       <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            min_reg       <= min_next;
            max_reg       <= max_next;
            step_reg      <= step_next;
            rated_reg     <= rated_next;
            period_reg    <= period_next;
            tau_reg       <= tau_next;
            elapsed_reg   <= elapsed_next;
            cur_reg       <= cur_next;
            tog_reg       <= tog_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        quad_reg  <= quad_next;
        izero_reg <= izero_next;
        j_reg     <= j_next;
        frac_reg  <= frac_next;
        lj_reg    <= lj_next;
        f_reg     <= f_next;
        res_reg   <= res_next;
        level_reg <= level_next;
    end

    assign out_valid = out_valid_reg;
    assign level     = level_reg;

`ifndef SYNTHESIS
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg != S_IDLE))
        else $error("accepted word did not start the sequencer");

    a_div_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (state_reg == S_MOD || state_reg == S_PHASE ||
                           state_reg == S_RDIV || state_reg == S_FDIV))
        else $error("divider finished with no state waiting on it");

    a_done_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && out_free) |=> (out_valid && state_reg == S_IDLE))
        else $error("finished level not loaded into output register");
`endif

endmodule

/* verif/tb_multimode_test_signal_generator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_multimode_test_signal_generator: self-checking bench for the generator
// Runs directed ticks through every mode and corner setting, then a
// back-pressure test and randomized config phases. Each accepted tick is
// scored against a local fixed-point model of the five waveforms.
// ----------------------------------------------------------------------------
module tb_multimode_test_signal_generator;
    import mtsg_pkg::*;

    localparam int SIN_N = 1024;
    localparam int LAG_N = 1024;
    localparam longint CYCLE_LIMIT = 1000000;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [23:0]        dt_us;
    logic               command;
    logic               out_valid;
    logic               out_stall;
    logic signed [31:0] level;
    logic               cfg_we;
    logic [2:0]         cfg_addr;
    logic [31:0]        cfg_wdata;

    multimode_test_signal_generator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .dt_us     (dt_us),
        .command   (command),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .level     (level),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    // ------------------------------------------------------------------
    // Model state: config copy, waveform state and the two ROM images
    // ------------------------------------------------------------------
    logic [15:0]       sin_rom [SIN_N];
    logic [15:0]       lag_rom [LAG_N + 1];
    logic [2:0]        gen_mode;
    longint            lvl_lo, lvl_hi, lvl_rated, acc_level;
    longint unsigned   step_amt, per_us, tau_val, t_elapsed;
    bit                toggle_state;

    logic signed [31:0] level_q [$];    // expected levels, oldest first
    int     n_err = 0;
    longint cycles = 0;
    bit     quiet;          // long stretch with no idling on either side
    bit     hold_req;       // flipped by the pressure test to ask for a hold-off
    bit     hold_taken;     // last request served by the receiver
    int     hold_cycles;    // receiver hold-off for the pressure test

    // ------------------------------------------------------------------
    // Clock, cycle limit
    // ------------------------------------------------------------------
    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // ROM images, built from the same integer series the block uses
    // ------------------------------------------------------------------
    function automatic logic [15:0] quarter_sine(input longint unsigned x);
        longint unsigned x2, term, pos, neg, s, r;
        x2 = (x * x) >> 30;
        term = x;
        pos = x;
        neg = 0;
        for (int k = 1; k <= 9; k++)
        begin
            term = ((term * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
            if (k % 2) neg += term; else pos += term;
        end
        s = (pos >= neg) ? pos - neg : 0;
        r = (s + 8192) >> 14;
        return (r > 65535) ? 16'hFFFF : r[15:0];
    endfunction

    function automatic logic [15:0] one_minus_exp(input longint unsigned y);
        longint unsigned one, term, pos, neg, e, r;
        one = 64'd1 << 30;
        term = one;
        pos = one;
        neg = 0;
        for (int k = 1; k <= 13; k++)
        begin
            term = ((term * y) >> 30) / longint'(k);
            if (k % 2) neg += term; else pos += term;
        end
        e = (pos >= neg) ? pos - neg : 0;
        for (int k = 0; k < 3; k++) e = (e * e) >> 30;
        if (e > one) e = one;
        r = ((one - e) + 8192) >> 14;
        return (r > 65535) ? 16'hFFFF : r[15:0];
    endfunction

    function automatic longint floor_q(input longint x, input longint d);
        longint q;
        q = x / d;
        if ((x % d) != 0 && x < 0) q -= 1;
        return q;
    endfunction

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // any register write restarts the waveform
    function automatic void restart_wave();
        t_elapsed = 0;
        acc_level = (gen_mode == MODE_COUNTER) ? lvl_lo : 0;
        toggle_state = 1'b1;
    endfunction

    // next level for one tick; advances the model state
    function automatic logic signed [31:0] next_level(input logic [23:0] dt,
                                                      input logic cmd);
        longint unsigned per, tau, ph, mag, pos, j, frac, f;
        longint s, span, q, lv, target;
        int quad, idx;
        per = (per_us == 0) ? 1 : per_us;
        lv = 0;
        case (gen_mode)
            MODE_SINE:
            begin
                t_elapsed = (t_elapsed + dt) % per;
                ph = (t_elapsed << 12) / per;
                quad = int'((ph >> 10) & 3);
                idx = int'(ph & 1023);
                if (quad % 2) s = (idx == 0) ? 65536 : longint'(sin_rom[SIN_N - idx]);
                else s = longint'(sin_rom[idx]);
                if (quad >= 2) s = -s;
                lv = floor_q((lvl_lo + lvl_hi) * 65536 + (lvl_hi - lvl_lo) * s, 131072);
            end
            MODE_RAMP:
            begin
                t_elapsed = (t_elapsed + dt) % per;
                span = lvl_hi - lvl_lo;
                mag = (span < 0) ? -span : span;
                q = longint'((mag * t_elapsed) / per);
                lv = (span < 0) ? lvl_lo - q : lvl_lo + q;
            end
            MODE_COUNTER:
            begin
                acc_level += longint'(step_amt);
                if (acc_level > lvl_hi) acc_level = lvl_lo;
                acc_level = clamp32(acc_level);
                lv = acc_level;
            end
            MODE_TOGGLE:
            begin
                t_elapsed = t_elapsed + dt;
                if (t_elapsed >= per)
                begin
                    t_elapsed = t_elapsed % per;
                    toggle_state = ~toggle_state;
                end
                lv = toggle_state ? 65536 : 0;
            end
            MODE_FOLLOW:
            begin
                tau = (tau_val == 0) ? 1 : tau_val;
                pos = (longint'(dt) << 23) / tau;
                j = pos >> 16;
                frac = pos & 16'hFFFF;
                target = cmd ? lvl_rated : 0;
                if (j >= LAG_N)
                    acc_level = clamp32(target);
                else
                begin
                    f = lag_rom[j];
                    if (lag_rom[j + 1] >= lag_rom[j])
                        f += (longint'(lag_rom[j + 1] - lag_rom[j]) * frac) >> 16;
                    acc_level = clamp32(acc_level +
                        floor_q((target - acc_level) * longint'(f), 65536));
                end
                lv = acc_level;
            end
            default: lv = 0;    // unused codes hold state
        endcase
        return 32'(clamp32(lv));
    endfunction

    // ------------------------------------------------------------------
    // Idling helpers
    // ------------------------------------------------------------------
    function automatic bit take_gap();
        return !quiet && ($urandom_range(0, 99) < 31);
    endfunction

    // receiver: random stalls, plus a counted hold-off when asked
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            out_stall   <= 1'b0;
            hold_cycles <= 0;
            hold_taken  <= hold_req;
        end
        else if (hold_cycles > 0)
        begin
            out_stall <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end
        else if (hold_req != hold_taken)
        begin
            out_stall   <= 1'b1;
            hold_cycles <= 399;
            hold_taken  <= hold_req;
        end
        else
            out_stall <= take_gap();
    end

    // scoreboard: each level word against the oldest expectation
    always @(posedge clk)
    begin
        logic signed [31:0] exp_lvl;
        if (rst_n && out_valid && !out_stall)
        begin
            if (level_q.size() == 0)
            begin
                n_err++;
                if (n_err <= 10) $display("unexpected level word %0d", level);
            end
            else
            begin
                exp_lvl = level_q.pop_front();
                if (level !== exp_lvl)
                begin
                    n_err++;
                    if (n_err <= 10)
                        $display("level mismatch: expected %0d got %0d", exp_lvl, level);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Driver tasks
    // ------------------------------------------------------------------
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        case (idx)
            CFG_MODE:   gen_mode = val[2:0];
            CFG_MIN:    lvl_lo = longint'(signed'(val));
            CFG_MAX:    lvl_hi = longint'(signed'(val));
            CFG_STEP:   step_amt = val[30:0];
            CFG_RATED:  lvl_rated = longint'(signed'(val));
            CFG_PERIOD: per_us = val;
            CFG_TAU:    tau_val = val;
            default: ;
        endcase
        restart_wave();
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // one tick word; valid stays up when the next word follows directly
    task automatic send_tick(input logic [23:0] dt, input logic cmd);
        @(negedge clk);
        while (take_gap())
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        dt_us <= dt;
        command <= cmd;
        forever
        begin
            @(posedge clk);
            if (!in_stall) break;
        end
        level_q.push_back(next_level(dt, cmd));
    endtask

    // drop valid and let the block drain before touching config
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        wait (level_q.size() == 0);
        repeat (120) @(posedge clk);
    endtask

    function automatic logic [23:0] rand_dt();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 5) return 24'($urandom_range(0, 3000));
        if (pick < 8) return 24'($urandom);
        return (pick == 8) ? 24'hFFFFFF : 24'd0;
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'h7FFFFFFF;
            1: return 32'h80000000;
            2: return 32'(int'($urandom_range(0, 400)) - 200) << 16;
            default: return $urandom;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_counter_default();
        // reset config: counter from 0 toward 100.0 in 1.0 steps
        for (int i = 0; i < 4; i++) send_tick(24'($urandom), 1'b0);
        drain();
    endtask

    task automatic test_each_mode();
        write_reg(CFG_PERIOD, 32'd5000);
        write_reg(CFG_MODE, MODE_SINE);
        send_tick(24'd0, 1'b0);
        send_tick(24'd1250, 1'b0);      // quarter point
        send_tick(24'hFFFFFF, 1'b1);
        drain();
        write_reg(CFG_MODE, MODE_RAMP);
        send_tick(24'd2500, 1'b0);
        send_tick(24'd2499, 1'b0);
        drain();
        write_reg(CFG_MODE, MODE_TOGGLE);
        send_tick(24'd4999, 1'b0);
        send_tick(24'd1, 1'b0);         // reaches period exactly
        send_tick(24'hFFFFFF, 1'b0);
        drain();
        write_reg(CFG_MODE, MODE_FOLLOW);
        send_tick(24'd100000, 1'b1);
        send_tick(24'hFFFFFF, 1'b1);    // largest tick, ratio still inside the table
        send_tick(24'd0, 1'b0);
        send_tick(24'd500000, 1'b0);
        drain();
        write_reg(CFG_MODE, 3'd6);      // unused code
        send_tick(24'd77, 1'b1);
        drain();
    endtask

    task automatic test_corner_config();
        write_reg(CFG_PERIOD, 32'd0);   // zero period acts as one
        write_reg(CFG_TAU, 32'd0);
        write_reg(CFG_MODE, MODE_TOGGLE);
        send_tick(24'd3, 1'b0);
        drain();
        write_reg(CFG_MODE, MODE_FOLLOW);
        write_reg(CFG_RATED, 32'h80000000);
        send_tick(24'd0, 1'b1);
        drain();
        // inverted range: sine and ramp run upside down
        write_reg(CFG_MIN, 32'h7FFFFFFF);
        write_reg(CFG_MAX, 32'h80000000);
        write_reg(CFG_PERIOD, 32'hFFFFFFFF);
        write_reg(CFG_MODE, MODE_RAMP);
        send_tick(24'hFFFFFF, 1'b0);
        drain();
        write_reg(CFG_MODE, MODE_SINE);
        send_tick(24'hABCDEF, 1'b0);
        drain();
        write_reg(CFG_MODE, MODE_COUNTER);
        send_tick(24'd1, 1'b0);
        drain();
        // zero step stays at min; huge step wraps back to min
        write_reg(CFG_MIN, 32'h7FFF0000);
        write_reg(CFG_MAX, 32'h7FFFFFFF);
        write_reg(CFG_STEP, 32'h80000000);
        send_tick(24'd1, 1'b0);
        drain();
        write_reg(CFG_STEP, 32'h7FFFFFFF);
        send_tick(24'd1, 1'b0);
        drain();
    endtask

    task automatic test_backpressure();
        write_reg(CFG_MIN, 32'h0);
        write_reg(CFG_MAX, 32'd6553600);
        write_reg(CFG_STEP, 32'd65536);
        write_reg(CFG_MODE, MODE_COUNTER);
        hold_req = ~hold_req;
        for (int i = 0; i < 20; i++) send_tick(24'($urandom), 1'b0);
        drain();
    endtask

    task automatic test_random();
        logic [2:0] m;
        int n;
        for (int ph = 0; ph < 20; ph++)
        begin
            quiet = (ph == 7 || ph == 8);
            m = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
                                             : 3'($urandom_range(0, 4));
            write_reg(CFG_MIN, rand_word());
            write_reg(CFG_MAX, rand_word());
            write_reg(CFG_STEP, $urandom_range(0, 3) == 0 ? $urandom : 32'd65536 * 7);
            write_reg(CFG_RATED, rand_word());
            write_reg(CFG_PERIOD, $urandom_range(0, 1) ? 32'($urandom_range(0, 20000))
                                                      : $urandom);
            write_reg(CFG_TAU, $urandom_range(0, 1) ? 32'($urandom_range(0, 2000000))
                                                   : $urandom);
            write_reg(CFG_MODE, m);
            n = $urandom_range(40, 75);
            for (int i = 0; i < n; i++) send_tick(rand_dt(), 1'($urandom));
            drain();
        end
        quiet = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        dt_us = '0;
        command = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = CFG_MODE;
        cfg_wdata = '0;
        quiet = 1'b0;
        for (int i = 0; i < SIN_N; i++)
            sin_rom[i] = quarter_sine((PI_Q30 * longint'(i)) >> 11);
        for (int i = 0; i <= LAG_N; i++)
            lag_rom[i] = one_minus_exp(longint'(i) << 20);
        gen_mode = MODE_COUNTER;
        lvl_lo = 0;
        lvl_hi = 6553600;
        step_amt = 65536;
        lvl_rated = 95027200;
        per_us = 30000000;
        tau_val = 3000000;
        restart_wave();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_counter_default();
        test_each_mode();
        test_corner_config();
        test_backpressure();
        test_random();

        if (n_err == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
